// ----- hdl/rrp_pkg.sv -----
// shared types and constants of the request parser
package rrp_pkg;

   localparam int EVENT_BITS = 4;
   localparam int ARG_BITS   = 4;
   localparam int FIELD_BITS = 24;
   localparam int BYTE_BITS  = 8;

   typedef logic [EVENT_BITS-1:0] event_type;
   typedef logic [ARG_BITS-1:0]   arg_type;
   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [BYTE_BITS-1:0]  byte_type;

   localparam event_type EV_NONE      = 4'd0;
   localparam event_type EV_PAYLOAD   = 4'd1;
   localparam event_type EV_ARG_DONE  = 4'd2;
   localparam event_type EV_REQ_DONE  = 4'd3;
   localparam event_type EV_NOT_ARRAY = 4'd4;
   localparam event_type EV_NO_ARGS   = 4'd5;
   localparam event_type EV_TOO_MANY  = 4'd6;
   localparam event_type EV_NOT_BULK  = 4'd7;
   localparam event_type EV_TOO_BIG   = 4'd8;

   localparam byte_type CHAR_STAR   = 8'h2A;
   localparam byte_type CHAR_DOLLAR = 8'h24;
   localparam byte_type CHAR_LF     = 8'h0A;
   localparam byte_type CHAR_ZERO   = 8'h30;
   localparam byte_type CHAR_NINE   = 8'h39;

   localparam logic CSR_PAYLOAD_LIMIT  = 1'b0;
   localparam logic CSR_ARGUMENT_LIMIT = 1'b1;

   localparam field_type PAYLOAD_LIMIT_RESET = 24'd8388608;
   localparam arg_type   ARGUMENT_LIMIT_RESET = 4'd8;
   localparam field_type FIELD_MAX = 24'hFFFFFF;
   localparam arg_type   ARG_MAX   = 4'hF;

endpackage

// ----- hdl/resp_request_parser.sv -----
// byte-wise parser for array-of-bulk-string requests
//
// One request byte enters per transfer on the req_ channel; one result leaves
// per byte on the rsp_ channel, carrying an event code, the payload byte, the
// argument index, the announced argument count and the announced length.
// Event codes: none, payload byte, argument done, request done, and the
// format errors not array, no arguments, too many, not string, too big.
// After an error the parser skips to the next line feed and waits for '*'.
// The byte is captured in an input register; the parse state and the result
// register are updated from it when the result register is free or taken, so
// a byte passes the input register and then the result register on its way
// to the rsp_ channel. One byte is taken every cycle while req_stall is low.
// This rate is set by the single state update per byte (accumulator times
// ten plus a digit, one compare against the limits).
// When the receiver stalls, the result holds and one more byte is still
// taken into the input register; req_stall rises only when both are full.
// The csr_ channel writes payload_limit (index 0) and argument_limit (index 1)
// and is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. Synchronous reset clears the
// handshake and parse state and loads the default limits.
module resp_request_parser #(
   parameter int LENGTH_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rrp_pkg::byte_type   req_byte_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rrp_pkg::event_type  rsp_event_res,
   output rrp_pkg::byte_type   rsp_data_byte,
   output rrp_pkg::arg_type    rsp_argument_number,
   output rrp_pkg::arg_type    rsp_argument_count,
   output rrp_pkg::field_type  rsp_argument_length,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  rrp_pkg::field_type  csr_data
);
   import rrp_pkg::*;

   localparam int LW = LENGTH_BITS + 1;
   localparam int MW = LENGTH_BITS + 5;
   localparam int CW = (LW > FIELD_BITS + 1) ? LW : FIELD_BITS + 1;
   localparam logic [LW-1:0] NUM_CAP = LW'(1) << LENGTH_BITS;

   localparam logic [2:0] MODE_AWAIT   = 3'd0;
   localparam logic [2:0] MODE_COUNT   = 3'd1;
   localparam logic [2:0] MODE_HMARK   = 3'd2;
   localparam logic [2:0] MODE_LENGTH  = 3'd3;
   localparam logic [2:0] MODE_PAYLOAD = 3'd4;
   localparam logic [2:0] MODE_SKIP    = 3'd5;

   // configuration
   field_type payload_limit_ff;
   arg_type   argument_limit_ff;

   // input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;

   // parse state
   logic [2:0]    mode_ff, mode_in;
   arg_type       count_ff, count_in;
   arg_type       cur_ff, cur_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic          ended_ff, ended_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   event_type ev_ff, ev_in;
   byte_type  data_ff, data_in;
   arg_type   argnum_ff, argnum_in;
   field_type outlen_ff;

   logic          req_take, fire;
   logic          is_digit, is_lf;
   logic [MW-1:0] mult_sum;
   logic [LW-1:0] digit_val;
   logic [LW-1:0] rem_dec;
   logic [CW-1:0] len_wide, plimit_wide, field_max_wide, len_in_wide;
   logic          len_zero, len_sat;
   logic [ARG_BITS:0] next_arg;

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   assign is_lf    = (in_byte_ff == CHAR_LF);
   assign is_digit = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign digit_val = LW'(in_byte_ff - CHAR_ZERO);
   assign mult_sum = (MW'(len_ff) << 3) + (MW'(len_ff) << 1) + MW'(digit_val);
   assign rem_dec  = (rem_ff != '0) ? rem_ff - LW'(1) : rem_ff;
   assign len_wide    = CW'(len_ff);
   assign plimit_wide = CW'(payload_limit_ff);
   assign field_max_wide = CW'(FIELD_MAX);
   assign len_in_wide = CW'(len_in);
   assign len_zero = (len_ff == '0);
   assign len_sat  = (len_ff >= NUM_CAP);
   assign next_arg = {1'b0, cur_ff} + (ARG_BITS+1)'(1);

   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      ended_in  = ended_ff;
      ev_in     = EV_NONE;
      data_in   = '0;
      argnum_in = '0;
      case (mode_ff)
         MODE_AWAIT: begin
            if (in_byte_ff == CHAR_STAR) begin
               mode_in  = MODE_COUNT;
               count_in = '0;
               cur_in   = '0;
               rem_in   = '0;
               len_in   = '0;
               ended_in = 1'b0;
            end else begin
               ev_in   = EV_NOT_ARRAY;
               mode_in = is_lf ? MODE_AWAIT : MODE_SKIP;
            end
         end
         MODE_COUNT, MODE_LENGTH: begin
            if (!is_lf) begin
               if (!ended_ff) begin
                  if (is_digit) begin
                     len_in = (mult_sum > MW'(NUM_CAP)) ? NUM_CAP : mult_sum[LW-1:0];
                  end else begin
                     ended_in = 1'b1;
                  end
               end
            end else if (mode_ff == MODE_COUNT) begin
               count_in = (len_ff > LW'(ARG_MAX)) ? ARG_MAX : len_ff[ARG_BITS-1:0];
               if (len_zero) begin
                  ev_in   = EV_NO_ARGS;
                  mode_in = MODE_AWAIT;
               end else if (len_sat || len_ff > LW'(argument_limit_ff)) begin
                  ev_in   = EV_TOO_MANY;
                  mode_in = MODE_AWAIT;
               end else begin
                  mode_in = MODE_HMARK;
                  cur_in  = '0;
               end
               len_in = '0;
            end else begin
               if (len_sat || len_wide > plimit_wide) begin
                  ev_in   = EV_TOO_BIG;
                  mode_in = MODE_AWAIT;
               end else begin
                  rem_in  = len_ff + LW'(2);
                  mode_in = MODE_PAYLOAD;
               end
            end
         end
         MODE_HMARK: begin
            if (in_byte_ff == CHAR_DOLLAR) begin
               mode_in  = MODE_LENGTH;
               len_in   = '0;
               ended_in = 1'b0;
            end else begin
               ev_in   = EV_NOT_BULK;
               mode_in = is_lf ? MODE_AWAIT : MODE_SKIP;
            end
         end
         MODE_PAYLOAD: begin
            if (rem_ff > LW'(2)) begin
               ev_in   = EV_PAYLOAD;
               data_in = in_byte_ff;
            end
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               if (next_arg >= {1'b0, count_ff}) begin
                  ev_in   = EV_REQ_DONE;
                  mode_in = MODE_AWAIT;
               end else begin
                  ev_in   = EV_ARG_DONE;
                  cur_in  = next_arg[ARG_BITS-1:0];
                  mode_in = MODE_HMARK;
               end
            end
         end
         MODE_SKIP: begin
            if (is_lf) begin
               mode_in = MODE_AWAIT;
            end
         end
         default: begin
            mode_in = MODE_AWAIT;
         end
      endcase
      if (mode_ff == MODE_PAYLOAD && rem_dec == '0) begin
         argnum_in = cur_ff;
      end else begin
         argnum_in = cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_limit_ff  <= PAYLOAD_LIMIT_RESET;
         argument_limit_ff <= ARGUMENT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAYLOAD_LIMIT: begin
               payload_limit_ff <= csr_data;
            end
            CSR_ARGUMENT_LIMIT: begin
               argument_limit_ff <= csr_data[ARG_BITS-1:0];
            end
            default: begin
               payload_limit_ff <= payload_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_AWAIT;
         count_ff     <= '0;
         cur_ff       <= '0;
         len_ff       <= '0;
         rem_ff       <= '0;
         ended_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            cur_ff   <= cur_in;
            len_ff   <= len_in;
            rem_ff   <= rem_in;
            ended_ff <= ended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_in;
      end
      if (fire) begin
         ev_ff     <= ev_in;
         data_ff   <= data_in;
         argnum_ff <= argnum_in;
         outlen_ff <= (len_in_wide > field_max_wide) ? FIELD_MAX
                                                     : len_in_wide[FIELD_BITS-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = ev_ff;
   assign rsp_data_byte       = data_ff;
   assign rsp_argument_number = argnum_ff;
   assign rsp_argument_count  = count_ff;
   assign rsp_argument_length = outlen_ff;

   // a captured byte is never lost before it is parsed
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff)
      else $error("input register dropped a byte");

   // a payload byte always leaves the parser still inside the argument
   a_payload_mode: assert property (@(posedge clock) disable iff (reset)
      fire && ev_in == EV_PAYLOAD |=> mode_ff == MODE_PAYLOAD)
      else $error("payload byte left payload mode");

   // payload mode always has bytes left to consume
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_PAYLOAD |-> rem_ff != '0)
      else $error("payload mode with no bytes left");

   // request done only on the last announced argument
   a_req_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ev_ff == EV_REQ_DONE |->
         ({1'b0, argnum_ff} + (ARG_BITS+1)'(1)) >= {1'b0, count_ff})
      else $error("request done before last argument");

endmodule
